// ----- rtl/core/lps_pkg.sv -----
`default_nettype none

package lps_pkg;

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BOOT_W  = 32;
    localparam int unsigned CONF_W  = 8;
    localparam int unsigned AGE_W   = 16;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDATA_W = 16;

    // config reset values
    localparam logic [AGE_W-1:0]  MAX_AGE_RST  = 16'd200;
    localparam logic [AGE_W-1:0]  RETRY_RST    = 16'd100;
    localparam logic [CONF_W-1:0] MIN_CONF_RST = 8'd128;

    // event codes
    typedef enum logic [1:0] {
        FN_REPORT    = 2'd0,
        FN_TICK      = 2'd1,
        FN_RESEED    = 2'd2,
        FN_START_ACK = 2'd3
    } func_t;

    // reseed request outcome codes
    localparam logic [1:0] SET_NONE      = 2'd0;
    localparam logic [1:0] SET_REJECTED  = 2'd1;
    localparam logic [1:0] SET_REQUESTED = 2'd2;

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_MAX_AGE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RETRY    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_CONF = 2'd2;

    typedef struct packed {
        func_t             func;
        logic [TIME_W-1:0] now_ms;
        logic [BOOT_W-1:0] boot_id;
        logic              reset_flag;
        logic [CONF_W-1:0] confidence;
    } item_t;

    typedef struct packed {
        logic              healthy;
        logic              send_reseed;
        logic [1:0]        set_result;
        logic [TIME_W-1:0] age_ms;
        logic              reseed_pending;
        logic              restart_seen;
    } result_t;

    typedef struct packed {
        logic [AGE_W-1:0]  max_age_ms;
        logic [AGE_W-1:0]  retry_ms;
        logic [CONF_W-1:0] min_confidence;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/lps_cfg_regs.sv -----
`default_nettype none

module lps_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [lps_pkg::CIDX_W-1:0]  wr_index,
    input  wire logic [lps_pkg::CDATA_W-1:0] wr_data,
    output lps_pkg::cfg_t                    cfg
);
    import lps_pkg::*;

    cfg_t cfg_reg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_age_ms     <= MAX_AGE_RST;
            cfg_reg.retry_ms       <= RETRY_RST;
            cfg_reg.min_confidence <= MIN_CONF_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MAX_AGE:  cfg_reg.max_age_ms     <= wr_data;
                CFG_RETRY:    cfg_reg.retry_ms       <= wr_data;
                CFG_MIN_CONF: cfg_reg.min_confidence <= wr_data[CONF_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lps_in_reg.sv -----
`default_nettype none

module lps_in_reg (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire lps_pkg::item_t in_item,
    output logic         item_valid,
    output lps_pkg::item_t item,
    input  wire logic    advance
);
    import lps_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready = !valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lps_core.sv -----
`default_nettype none

module lps_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire lps_pkg::item_t  item,
    input  wire lps_pkg::cfg_t   cfg,
    output lps_pkg::result_t res
);
    import lps_pkg::*;

    logic              have_report_reg, have_report_next;
    logic              have_boot_reg, have_boot_next;
    logic [BOOT_W-1:0] last_boot_reg, last_boot_next;
    logic              restart_reg, restart_next;
    logic [TIME_W-1:0] arrival_reg, arrival_next;
    logic [CONF_W-1:0] conf_reg, conf_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] sent_reg, sent_next;

    logic [TIME_W-1:0] age_before;
    logic [TIME_W-1:0] age_after;
    logic [TIME_W-1:0] since_sent;
    logic [TIME_W-1:0] max_age_w;
    logic [TIME_W-1:0] retry_w;
    logic              stale;
    logic              send;
    logic [1:0]        set_res;

    assign max_age_w = {{(TIME_W-AGE_W){1'b0}}, cfg.max_age_ms};
    assign retry_w   = {{(TIME_W-AGE_W){1'b0}}, cfg.retry_ms};

    // age of the stored report before this event
    assign age_before = have_report_reg ? (item.now_ms - arrival_reg) : '1;
    assign stale      = age_before > max_age_w;
    assign since_sent = item.now_ms - sent_reg;

    // event handling
    always_comb
    begin
        have_report_next = have_report_reg;
        have_boot_next   = have_boot_reg;
        last_boot_next   = last_boot_reg;
        restart_next     = restart_reg;
        arrival_next     = arrival_reg;
        conf_next        = conf_reg;
        pending_next     = pending_reg;
        sent_next        = sent_reg;
        send             = 1'b0;
        set_res          = SET_NONE;
        case (item.func)
            FN_REPORT:
            begin
                if (have_boot_reg && (item.boot_id != last_boot_reg))
                    restart_next = 1'b1;
                last_boot_next   = item.boot_id;
                have_boot_next   = 1'b1;
                have_report_next = 1'b1;
                conf_next        = item.confidence;
                arrival_next     = item.now_ms;
                // reseed confirmed by the far end
                if (pending_reg && item.reset_flag)
                begin
                    pending_next = 1'b0;
                    restart_next = 1'b0;
                end
            end
            FN_TICK:
            begin
                if (pending_reg && (since_sent >= retry_w))
                begin
                    send      = 1'b1;
                    sent_next = item.now_ms;
                end
            end
            FN_RESEED:
            begin
                if (stale)
                    set_res = SET_REJECTED;
                else
                begin
                    pending_next = 1'b1;
                    send         = 1'b1;
                    sent_next    = item.now_ms;
                    set_res      = SET_REQUESTED;
                end
            end
            FN_START_ACK:
            begin
                if (have_report_reg)
                    restart_next = 1'b0;
            end
            default: ;
        endcase
    end

    // age and health after the update
    assign age_after = have_report_next ? (item.now_ms - arrival_next) : '1;

    always_comb
    begin
        res.healthy        = have_report_next && !restart_next
                             && (age_after <= max_age_w)
                             && (conf_next >= cfg.min_confidence);
        res.send_reseed    = send;
        res.set_result     = set_res;
        res.age_ms         = age_after;
        res.reseed_pending = pending_next;
        res.restart_seen   = restart_next;
    end

    // link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_report_reg <= 1'b0;
            have_boot_reg   <= 1'b0;
            last_boot_reg   <= '0;
            restart_reg     <= 1'b0;
            arrival_reg     <= '0;
            conf_reg        <= '0;
            pending_reg     <= 1'b0;
            sent_reg        <= '0;
        end
        else if (en)
        begin
            have_report_reg <= have_report_next;
            have_boot_reg   <= have_boot_next;
            last_boot_reg   <= last_boot_next;
            restart_reg     <= restart_next;
            arrival_reg     <= arrival_next;
            conf_reg        <= conf_next;
            pending_reg     <= pending_next;
            sent_reg        <= sent_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lps_out_reg.sv -----
`default_nettype none

module lps_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire lps_pkg::result_t  res,
    output logic              can_load,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lps_pkg::result_t  out_res
);
    import lps_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- rtl/core/link_pose_supervisor_top.sv -----
`default_nettype none

// channel | signals                          | direction
// --------+----------------------------------+----------
// in      | in_valid/in_ready, event fields  | request in
// out     | out_valid/out_ready, result flds | request out
// cfg     | cfg_valid/cfg_ready, index, data | write in
//
// one request per cycle sustained while out_ready is high; an accepted request
// passes the input register, a single update pass and the result register
// reset clears link state and loads config defaults; no clearing pass
// a stalled result holds while the input register still takes one request
// config writes are always ready and are registered

module link_pose_supervisor_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  func,
    input  wire logic [lps_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [lps_pkg::BOOT_W-1:0]  boot_id,
    input  wire logic                        reset_flag,
    input  wire logic [lps_pkg::CONF_W-1:0]  confidence,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             healthy,
    output logic                             send_reseed,
    output logic [1:0]                       set_result,
    output logic [lps_pkg::TIME_W-1:0]       age_ms,
    output logic                             reseed_pending,
    output logic                             restart_seen,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lps_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [lps_pkg::CDATA_W-1:0] cfg_data
);
    import lps_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    advance;
    cfg_t    cfg;
    result_t res;
    result_t out_res;

    // request payload packing
    always_comb
    begin
        in_item.func       = func_t'(func);
        in_item.now_ms     = now_ms;
        in_item.boot_id    = boot_id;
        in_item.reset_flag = reset_flag;
        in_item.confidence = confidence;
    end

    assign advance   = item_valid && can_load;
    assign cfg_ready = 1'b1;

    lps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lps_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    lps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    lps_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // result unpacking
    assign healthy        = out_res.healthy;
    assign send_reseed    = out_res.send_reseed;
    assign set_result     = out_res.set_result;
    assign age_ms         = out_res.age_ms;
    assign reseed_pending = out_res.reseed_pending;
    assign restart_seen   = out_res.restart_seen;

endmodule

`default_nettype wire

// ----- rtl/core/lps_checker.sv -----
`default_nettype none

module lps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        healthy,
    input wire logic        send_reseed,
    input wire logic [1:0]  set_result,
    input wire logic [31:0] age_ms,
    input wire logic        reseed_pending,
    input wire logic        restart_seen
);
    import lps_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(age_ms)
        && $stable(set_result) && $stable(healthy))
        else $error("stalled result changed");

    // a resend only goes out while a reseed is outstanding
    a_send_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_reseed |-> reseed_pending)
        else $error("reseed sent without pending");

    // outcome codes agree with the send strobe
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (set_result != 2'd3)
        && !(set_result == SET_REJECTED && send_reseed)
        && !(set_result == SET_REQUESTED && !send_reseed))
        else $error("reseed outcome inconsistent");

    // health needs no latched restart and an age within the 16 bit limit
    a_healthy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && healthy |-> !restart_seen && (age_ms[31:16] == 16'd0))
        else $error("healthy with restart or old report");

endmodule

bind link_pose_supervisor_top lps_checker u_lps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .healthy        (healthy),
    .send_reseed    (send_reseed),
    .set_result     (set_result),
    .age_ms         (age_ms),
    .reseed_pending (reseed_pending),
    .restart_seen   (restart_seen)
);

`default_nettype wire
